[hw/rtl/ipq_pkg.sv]
package ipq_pkg;

    // Default queue depth
    localparam int IPQ_DEPTH_DEF = 16;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd3;

    // Id that means "no interrupt"
    localparam logic [ID_W-1:0] ID_NONE = 8'd0;

    // One queued request: id in the upper byte, priority in the lower
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

endpackage

[hw/rtl/interrupt_priority_queue_unit.sv]
// Sorted priority queue of pending interrupt requests (lower value = more urgent).
// Input stream (s side): tuser carries the command (push, pop, clear); tdata
// carries the interrupt id and priority. Every accepted beat yields exactly
// one output beat (m side): tuser carries the status, tdata the served id,
// served priority and the entry count after the command.
// Entries sit in a circular buffer in a one-read, one-write RAM with a head
// pointer. A pop reads the head entry and advances the pointer. A push walks
// from the tail toward the front, one entry at a time (read, then compare)
// through a single priority comparator, moving each larger entry one slot
// back until the insert point is found or the front is reached.
// Ignored/dropped pushes, clear and the unused command go straight to the
// output stage. One item is in work at a time; the input is ready again once
// the result sits in the output register.
// Reset empties the queue (the RAM itself is not cleared, only count and head).
// When the receiver stalls, the result is held in the output register; the
// next item is still accepted and worked on, and waits for the output
// register to free up before its own result is loaded.
module interrupt_priority_queue_unit #(
    parameter int DEPTH = ipq_pkg::IPQ_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input beats
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // irq_id[7:0], priority_req[15:8]
    input  logic [1:0]  i_s_tuser,   // command[1:0]
    // Result beats
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // served_id[7:0], served_priority[15:8],
                                     // entry_count[20:16], zero[23:21]
    output logic [1:0]  o_m_tuser    // status[1:0]
);
    import ipq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_INS_RD   = 5'b00010,
        S_INS_CMP  = 5'b00100,
        S_POP_DATA = 5'b01000,
        S_FIN      = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_k, n_k;
    logic [ID_W-1:0]     r_id, n_id;
    logic [PRIO_W-1:0]   r_prio, n_prio;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ID_W-1:0]     r_sid, n_sid;
    logic [PRIO_W-1:0]   r_sprio, n_sprio;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [ID_W-1:0]     r_o_sid;
    logic [PRIO_W-1:0]   r_o_sprio;
    logic [COUNT_W-1:0]  r_o_count;

    logic                w_accept;
    logic                w_load;
    logic                w_move;
    logic [CMD_W-1:0]    w_cmd;
    logic [AW:0]         w_sum_k, w_sum_km1, w_sum_head;
    logic [AW-1:0]       w_km1;
    logic [AW-1:0]       w_addr_k, w_addr_km1, w_head_inc;
    logic [31:0]         w_cnt32;

    logic                w_we;
    logic [AW-1:0]       w_raddr;
    t_entry              w_wdata, w_rd;

    assign w_cmd      = i_s_tuser;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == S_FIN) && (!r_out_valid || i_m_tready);
    assign w_move     = (w_rd.prio > r_prio);

    // Logical slot to RAM address (wrap around the circular buffer)
    assign w_km1      = r_k - AW'(1);
    assign w_sum_k    = {1'b0, r_head} + {1'b0, r_k};
    assign w_sum_km1  = {1'b0, r_head} + {1'b0, w_km1};
    assign w_sum_head = {1'b0, r_head} + (AW + 1)'(1);
    assign w_addr_k   = (w_sum_k >= (AW + 1)'(DEPTH)) ?
                        AW'(w_sum_k - (AW + 1)'(DEPTH)) : w_sum_k[AW-1:0];
    assign w_addr_km1 = (w_sum_km1 >= (AW + 1)'(DEPTH)) ?
                        AW'(w_sum_km1 - (AW + 1)'(DEPTH)) : w_sum_km1[AW-1:0];
    assign w_head_inc = (w_sum_head >= (AW + 1)'(DEPTH)) ?
                        AW'(w_sum_head - (AW + 1)'(DEPTH)) : w_sum_head[AW-1:0];

    // RAM port control: insert walk reads slot k-1, else the head
    assign w_raddr = (r_state == S_INS_RD) ? w_addr_km1 : r_head;
    assign w_we    = ((r_state == S_INS_RD) && (r_k == '0)) || (r_state == S_INS_CMP);
    assign w_wdata = ((r_state == S_INS_CMP) && w_move) ? w_rd : t_entry'{r_id, r_prio};

    ipq_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_addr_k),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rd)
    );

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_k      = r_k;
        n_id     = r_id;
        n_prio   = r_prio;
        n_status = r_status;
        n_sid    = r_sid;
        n_sprio  = r_sprio;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_id     = i_s_tdata[7:0];
                    n_prio   = i_s_tdata[15:8];
                    n_status = ST_OK;
                    n_sid    = '0;
                    n_sprio  = '0;
                    n_state  = S_FIN;
                    case (w_cmd)
                        CMD_PUSH: begin
                            if (i_s_tdata[7:0] == ID_NONE) begin
                                n_status = ST_NONE;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_k     = r_count[AW-1:0];
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_POP_DATA;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_head  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                // front reached: new entry goes to slot 0
                if (r_k == '0) begin
                    n_count = r_count + CW'(1);
                    n_state = S_FIN;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                // larger entry moves back one slot; else insert here
                if (w_move) begin
                    n_k     = w_km1;
                    n_state = S_INS_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = S_FIN;
                end
            end
            S_POP_DATA: begin
                n_sid   = w_rd.id;
                n_sprio = w_rd.prio;
                n_head  = w_head_inc;
                n_count = r_count - CW'(1);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_id     <= n_id;
        r_prio   <= n_prio;
        r_status <= n_status;
        r_sid    <= n_sid;
        r_sprio  <= n_sprio;
    end

    assign w_cnt32 = 32'(r_count);

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status <= r_status;
            r_o_sid    <= r_sid;
            r_o_sprio  <= r_sprio;
            r_o_count  <= w_cnt32[COUNT_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_o_status;
    assign o_m_tdata  = {3'b000, r_o_count, r_o_sprio, r_o_sid};

`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_walk_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INS_RD) || (r_state == S_INS_CMP)) |->
            ((r_k <= r_count[AW-1:0]) && (r_count < CW'(DEPTH))))
        else $error("insert walk outside held entries");

    a_insert_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INS_CMP) && !w_move) |=>
            ((r_count == $past(r_count) + CW'(1)) && (r_state == S_FIN)))
        else $error("insert did not add one entry");

    a_pop_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_DATA) |=>
            ((r_count == $past(r_count) - CW'(1)) && (r_state == S_FIN)))
        else $error("pop did not remove one entry");

    a_result_loaded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_m_tvalid && (r_state == S_IDLE)))
        else $error("result not presented after completion");
`endif

endmodule

[hw/rtl/ipq_ram.sv]
module ipq_ram #(
    parameter int DEPTH = ipq_pkg::IPQ_DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ipq_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output ipq_pkg::t_entry o_rdata
);
    import ipq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
